[sv/fac_pkg.sv]
package fac_pkg;

    // Default output scaling, fractional bits of cos_value and angle
    localparam int FRAC_BITS_DEF = 14;

    // Internal fixed point: Q2.30
    localparam int QI    = 30;
    localparam int X_W   = QI + 1;          // |x| up to one
    localparam int H_W   = 25;              // Horner terms, signed
    localparam int R_W   = 32;              // square root result
    localparam int RAD_W = 2 * R_W;         // square root radicand

    localparam int SQRT_STAGES = RAD_W / 2;
    localparam int POLY_STAGES = 14;
    localparam int H_DLY       = 2 * SQRT_STAGES - POLY_STAGES;
    localparam int LATENCY     = 2 * SQRT_STAGES + 4;

    // Coefficients times 2^30
    localparam logic signed [H_W-1:0] KA = 25'sd105018;
    localparam logic signed [H_W-1:0] KB = -25'sd1123005;
    localparam logic signed [H_W-1:0] KC = 25'sd4495929;
    localparam logic signed [H_W-1:0] KD = -25'sd3375275;
    // Leading coefficient is -(KA+KB+KC+KD), kept as its magnitude
    localparam logic [16:0]           KO_MAG = 17'd102667;
    localparam logic [31:0]           KE  = 32'd2942954541;
    localparam logic [31:0]           KF  = 32'd397701087;
    localparam logic [31:0]           KPI = 32'd3373259426;
    localparam logic [32:0]           TWO_Q = 33'h0_8000_0000;

    // Product rounded half up back to QI fractional bits
    function automatic logic [63-QI:0] qround(input logic [63:0] p);
        logic [63:0] s;
        s = p + (64'd1 << (QI - 1));
        return s[63:QI];
    endfunction

endpackage

[sv/fac_sqrt.sv]
module fac_sqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [fac_pkg::RAD_W-1:0]  rad,
    output logic [fac_pkg::R_W-1:0]    root
);
    import fac_pkg::*;

    localparam int N = SQRT_STAGES;

    logic [R_W+1:0]   rem_in    [N];
    logic [R_W-1:0]   root_in   [N];
    logic [RAD_W-1:0] rad_in    [N];
    logic [R_W+1:0]   rem_next  [N];
    logic [R_W-1:0]   root_next [N];

    logic [R_W+1:0]   rem_reg   [N-1];
    logic [R_W-1:0]   root_reg  [N];
    logic [RAD_W-1:0] rad_reg   [N-1];

    // One result bit per stage, top radicand pair first
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [R_W+1:0] cur;
        logic [R_W+1:0] trial;
        logic           take;

        if (i == 0)
        begin : g_first
            assign rem_in[i]  = '0;
            assign root_in[i] = '0;
            assign rad_in[i]  = rad;
        end
        else
        begin : g_next
            assign rem_in[i]  = rem_reg[i-1];
            assign root_in[i] = root_reg[i-1];
            assign rad_in[i]  = rad_reg[i-1];
        end

        assign cur          = {rem_in[i][R_W-1:0], rad_in[i][RAD_W-1 -: 2]};
        assign trial        = {root_in[i], 2'b01};
        assign take         = (cur >= trial);
        assign rem_next[i]  = take ? cur - trial : cur;
        assign root_next[i] = {root_in[i][R_W-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                root_reg[k] <= root_next[k];
            end
            for (int k = 0; k < N - 1; k++)
            begin
                rem_reg[k] <= rem_next[k];
                rad_reg[k] <= rad_in[k] << 2;
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

[sv/fac_poly.sv]
module fac_poly (
    input  logic                              clk,
    input  logic                              en,
    input  logic [fac_pkg::X_W-1:0]           x,
    output logic signed [fac_pkg::H_W-1:0]    h
);
    import fac_pkg::*;

    // Horner step tail: k + sign * round(p)
    function automatic logic signed [H_W-1:0] radd(
        input logic signed [H_W-1:0] k,
        input logic                  neg,
        input logic [63:0]           p
    );
        logic [63-QI:0]         q;
        logic signed [H_W-1:0]  r;
        q = qround(p);
        r = signed'({1'b0, q[H_W-2:0]});
        return neg ? k - r : k + r;
    endfunction

    logic [X_W-1:0] x_dly_reg  [1:12];
    logic [X_W-1:0] x2_dly_reg [2:10];
    logic [X_W-1:0] x3_dly_reg [4:8];
    logic [X_W-1:0] x4_reg;

    logic [2*X_W-1:0]        p1_reg, p3_reg, p5_reg;
    logic [17+X_W-1:0]       p7_reg;
    logic [H_W-1+X_W-1:0]    p9_reg, p11_reg, p13_reg;
    logic                    s9_reg, s11_reg, s13_reg;
    logic signed [H_W-1:0]   h1_reg, h2_reg, h3_reg, h4_reg;

    logic [H_W-2:0] m1, m2, m3;

    assign m1 = h1_reg[H_W-1] ? (H_W-1)'(-h1_reg) : h1_reg[H_W-2:0];
    assign m2 = h2_reg[H_W-1] ? (H_W-1)'(-h2_reg) : h2_reg[H_W-2:0];
    assign m3 = h3_reg[H_W-1] ? (H_W-1)'(-h3_reg) : h3_reg[H_W-2:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // powers of x
            p1_reg        <= x * x;
            x_dly_reg[1]  <= x;
            x2_dly_reg[2] <= X_W'(qround(64'(p1_reg)));
            p3_reg        <= x2_dly_reg[2] * x_dly_reg[2];
            x3_dly_reg[4] <= X_W'(qround(64'(p3_reg)));
            p5_reg        <= x3_dly_reg[4] * x_dly_reg[4];
            x4_reg        <= X_W'(qround(64'(p5_reg)));

            // Horner chain, sign and magnitude per step
            p7_reg  <= KO_MAG * x4_reg;
            h1_reg  <= radd(KA, 1'b1, 64'(p7_reg));
            p9_reg  <= m1 * x3_dly_reg[8];
            s9_reg  <= h1_reg[H_W-1];
            h2_reg  <= radd(KB, s9_reg, 64'(p9_reg));
            p11_reg <= m2 * x2_dly_reg[10];
            s11_reg <= h2_reg[H_W-1];
            h3_reg  <= radd(KC, s11_reg, 64'(p11_reg));
            p13_reg <= m3 * x_dly_reg[12];
            s13_reg <= h3_reg[H_W-1];
            h4_reg  <= radd(KD, s13_reg, 64'(p13_reg));

            for (int k = 2; k <= 12; k++)
            begin
                x_dly_reg[k] <= x_dly_reg[k-1];
            end
            for (int k = 3; k <= 10; k++)
            begin
                x2_dly_reg[k] <= x2_dly_reg[k-1];
            end
            for (int k = 5; k <= 8; k++)
            begin
                x3_dly_reg[k] <= x3_dly_reg[k-1];
            end
        end
    end

    assign h = h4_reg;

endmodule

[sv/fast_arccos_approx_core.sv]
// Fixed-point arc cosine.
// Input channel: cos_value (signed Q1.FRAC_BITS) with in_valid / in_stall.
// Output channel: angle (unsigned Q2.FRAC_BITS radians, 0 to pi) with
// out_valid / out_stall. A transfer happens on a rising clk edge where
// valid is high and stall is low.
// Inputs beyond plus or minus one are saturated. Negative inputs are
// mirrored as pi minus the result for the magnitude.
// From input transfer to out_valid the path runs through one input stage,
// two chained 32-stage square root pipelines (one result bit per stage),
// then a multiply, a combine and an output/rounding stage. The polynomial
// (14 stages) and the third root run alongside and are delayed to match.
// Throughput is one transfer per cycle while the output is not stalled.
// The whole pipeline advances together. While a result sits on the output
// with out_stall high, every stage holds and in_stall is raised; bubbles
// do not cost a stall otherwise.
// rst_n clears all valid bits asynchronously; data in flight is dropped.
module fast_arccos_approx_core #(
    parameter int FRAC_BITS = fac_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] cos_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        angle
);
    import fac_pkg::*;

    localparam int SH = QI - FRAC_BITS;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam int RH_SH = (SH == 0) ? 0 : SH - 1;
    localparam logic [32:0] ROUND_HALF = (SH == 0) ? 33'd0 : (33'd1 << RH_SH);

    logic vld_reg [1:LATENCY];

    // Pipeline advance: everything holds while the output is blocked
    logic en;
    assign en = !(vld_reg[LATENCY] && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LATENCY; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= LATENCY; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage 1: saturate, magnitude, scale to Q2.30
    logic signed [31:0] s_wide, s_sat;
    logic [16:0]        mag;
    logic [X_W-1:0]     x_next, x_reg;
    logic               neg_next, neg_reg;

    always_comb
    begin
        s_wide = 32'(cos_value);
        if (s_wide > ONE)
        begin
            s_sat = ONE;
        end
        else if (s_wide < -ONE)
        begin
            s_sat = -ONE;
        end
        else
        begin
            s_sat = s_wide;
        end
        neg_next = s_sat[31];
        mag      = neg_next ? 17'(-s_sat) : s_sat[16:0];
        x_next   = X_W'(mag) << SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            neg_reg <= neg_next;
        end
    end

    // Polynomial branch
    logic signed [H_W-1:0] h_poly;

    fac_poly u_poly (
        .clk (clk),
        .en  (en),
        .x   (x_reg),
        .h   (h_poly)
    );

    // Square root branch: s1 = sqrt(2+2x), s3 = sqrt(2-2x), s2 = sqrt(2-s1)
    logic [32:0]      t1, t2, t3;
    logic [RAD_W-1:0] rad1, rad2, rad3;
    logic [R_W-1:0]   s1, s1_clamp, s2, s3;

    assign t1   = TWO_Q + {1'b0, x_reg, 1'b0};
    assign t3   = TWO_Q - {1'b0, x_reg, 1'b0};
    assign rad1 = {1'b0, t1, 30'b0};
    assign rad3 = {1'b0, t3, 30'b0};

    fac_sqrt u_sqrt1 (
        .clk  (clk),
        .en   (en),
        .rad  (rad1),
        .root (s1)
    );

    fac_sqrt u_sqrt3 (
        .clk  (clk),
        .en   (en),
        .rad  (rad3),
        .root (s3)
    );

    assign s1_clamp = (s1 > TWO_Q[R_W-1:0]) ? TWO_Q[R_W-1:0] : s1;
    assign t2       = TWO_Q - {1'b0, s1_clamp};
    assign rad2     = {1'b0, t2, 30'b0};

    fac_sqrt u_sqrt2 (
        .clk  (clk),
        .en   (en),
        .rad  (rad2),
        .root (s2)
    );

    // Alignment delay lines
    logic [R_W-1:0]        s3_dly_reg  [SQRT_STAGES];
    logic signed [H_W-1:0] h_dly_reg   [H_DLY];
    logic                  neg_dly_reg [2*SQRT_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dly_reg[0]  <= s3;
            h_dly_reg[0]   <= h_poly;
            neg_dly_reg[0] <= neg_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                s3_dly_reg[k] <= s3_dly_reg[k-1];
            end
            for (int k = 1; k < H_DLY; k++)
            begin
                h_dly_reg[k] <= h_dly_reg[k-1];
            end
            for (int k = 1; k < 2 * SQRT_STAGES; k++)
            begin
                neg_dly_reg[k] <= neg_dly_reg[k-1];
            end
        end
    end

    // Multiply stage
    logic [63:0]           pe_reg, pf_reg;
    logic signed [H_W-1:0] h_m_reg;
    logic                  neg_m_reg;

    // Combine stage
    logic signed [35:0]    ac_next, ac_reg;
    logic                  neg_a_reg;

    assign ac_next = 36'(h_m_reg)
                   + signed'({2'b0, qround(pe_reg)})
                   - signed'({2'b0, qround(pf_reg)});

    // Output stage: clamp to [0, pi], mirror, round to FRAC_BITS
    logic [31:0]  acc_c, acc_m;
    logic [32:0]  acc_r;
    logic [15:0]  angle_next, angle_reg;

    always_comb
    begin
        if (ac_reg[35])
        begin
            acc_c = '0;
        end
        else if (ac_reg > signed'({4'b0, KPI}))
        begin
            acc_c = KPI;
        end
        else
        begin
            acc_c = ac_reg[31:0];
        end
        acc_m      = neg_a_reg ? KPI - acc_c : acc_c;
        acc_r      = ({1'b0, acc_m} + ROUND_HALF) >> SH;
        angle_next = acc_r[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pe_reg    <= KE * s2;
            pf_reg    <= KF * s3_dly_reg[SQRT_STAGES-1];
            h_m_reg   <= h_dly_reg[H_DLY-1];
            neg_m_reg <= neg_dly_reg[2*SQRT_STAGES-1];
            ac_reg    <= ac_next;
            neg_a_reg <= neg_m_reg;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = vld_reg[LATENCY];
    assign in_stall  = !en;
    assign angle     = angle_reg;

endmodule

[sv/fac_checker.sv]
module fac_checker #(
    parameter int FRAC_BITS = fac_pkg::FRAC_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] angle
);
    import fac_pkg::*;

    localparam int SH = QI - FRAC_BITS;
    localparam int RH_SH = (SH == 0) ? 0 : SH - 1;
    localparam logic [32:0] HALF = (SH == 0) ? 33'd0 : (33'd1 << RH_SH);
    localparam logic [32:0] PI_CODE = ({1'b0, KPI} + HALF) >> SH;
    // pi only fits the 16-bit port up to 14 fractional bits
    localparam bit RANGE_CHECK = (FRAC_BITS <= 14);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
        else $error("stalled result changed or dropped");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow blocked output");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && RANGE_CHECK |-> {17'b0, angle} <= PI_CODE)
        else $error("angle above pi");

    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight out of reset");

endmodule

bind fast_arccos_approx_core fac_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_fac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
);

[tb/tb_top.sv]
module tb_top;
    import fac_pkg::*;

    // Run length and watchdog
    localparam int N_RANDOM    = 1300;
    localparam int CALM_FIRST  = 500;     // first random item sent with no idling on either side
    localparam int CALM_LAST   = 799;
    localparam int HOLD_AT     = 300;     // items sent before the long receiver hold-off
    localparam int HOLD_CYCLES = 400;     // well beyond the 68-deep pipeline
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 38;

    // Angle model constants: Q2.30 internal, Q1.FB in and Q2.FB out at the ports
    localparam int      FB     = FRAC_BITS_DEF;
    localparam int      QF     = 30;
    localparam int      ONE_IN = 1 << FB;
    localparam longint  C_A    = 64'sd105018;
    localparam longint  C_B    = -64'sd1123005;
    localparam longint  C_C    = 64'sd4495929;
    localparam longint  C_D    = -64'sd3375275;
    localparam longint  C_O    = -(C_A + C_B + C_C + C_D);   // makes the polynomial zero at one
    localparam longint  C_E    = 64'sd2942954541;
    localparam longint  C_F    = 64'sd397701087;
    localparam longint  C_PI   = 64'sd3373259426;
    localparam int      ANGLE_PI = 51472;                    // pi at the output scale

    typedef bit [63:0] q64_t;
    localparam q64_t HALF_Q = q64_t'(1) << (QF - 1);
    localparam q64_t TWO_Q  = q64_t'(2) << QF;

    // Directed rows: the angle is typed in only where it is obvious
    typedef struct {
        int cos;
        bit known;
        int angle;
    } dir_row_t;

    localparam int N_DIR = 22;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] cos_value;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        angle;

    logic [15:0]        pending_angles [$];   // expected angles, oldest first
    int                 mismatches = 0;
    int                 items_sent = 0;
    bit                 calm = 1'b0;         // both sides run without idling
    int unsigned        cycle_cnt = 0;

    dir_row_t dir_rows [N_DIR] = '{
        '{16384,  1'b1, 0},          // cosine one: angle exactly zero
        '{-16384, 1'b1, ANGLE_PI},   // cosine minus one: angle pi
        '{16385,  1'b1, 0},          // just beyond one saturates
        '{-16385, 1'b1, ANGLE_PI},
        '{32767,  1'b1, 0},          // field extremes saturate
        '{-32768, 1'b1, ANGLE_PI},
        '{21845,  1'b1, 0},
        '{-21846, 1'b1, ANGLE_PI},
        '{0,      1'b0, 0},          // zero counts as non-negative
        '{1,      1'b0, 0},
        '{-1,     1'b0, 0},
        '{16383,  1'b0, 0},
        '{-16383, 1'b0, 0},
        '{8192,   1'b0, 0},
        '{-8192,  1'b0, 0},
        '{11585,  1'b0, 0},
        '{-11585, 1'b0, 0},
        '{10922,  1'b0, 0},
        '{-10923, 1'b0, 0},
        '{100,    1'b0, 0},
        '{-100,   1'b0, 0},
        '{16320,  1'b0, 0}
    };

    fast_arccos_approx_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cos_value (cos_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle     (angle)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Angle predictor, Q2.30 fixed point
    // ---------------------------------------------------------------

    // signed times unsigned, rounded half away from zero
    function automatic longint round_mul_s(input longint a, input q64_t x);
        bit   ng;
        q64_t m;
        q64_t p;
        ng = (a < 0);
        m  = ng ? q64_t'(-a) : q64_t'(a);
        p  = (m * x + HALF_Q) >> QF;
        return ng ? -$signed(p) : $signed(p);
    endfunction

    function automatic q64_t round_mul_u(input q64_t a, input q64_t b);
        return (a * b + HALF_Q) >> QF;
    endfunction

    // floor of the integer square root
    function automatic q64_t floor_root(input q64_t v);
        q64_t res;
        q64_t b;
        res = '0;
        b   = q64_t'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] predict_angle(input logic signed [15:0] c);
        longint s;
        longint h;
        longint ac;
        bit     ng;
        q64_t   x, x2, x3, x4, s1, s2, s3, r;
        s = c;
        if (s > ONE_IN)
            s = ONE_IN;
        if (s < -ONE_IN)
            s = -ONE_IN;
        ng = (s < 0);
        x  = q64_t'(ng ? -s : s) << (QF - FB);

        x2 = round_mul_u(x, x);
        x3 = round_mul_u(x2, x);
        x4 = round_mul_u(x3, x);

        // Horner form of the x^10, x^6, x^3, x and constant terms
        h = round_mul_s(C_O, x4) + C_A;
        h = round_mul_s(h, x3) + C_B;
        h = round_mul_s(h, x2) + C_C;
        h = round_mul_s(h, x) + C_D;

        s1 = floor_root((TWO_Q + 2 * x) << QF);
        if (s1 > TWO_Q)
            s1 = TWO_Q;
        s2 = floor_root((TWO_Q - s1) << QF);
        s3 = floor_root((TWO_Q - 2 * x) << QF);

        ac = h + round_mul_s(C_E, s2) - round_mul_s(C_F, s3);
        if (ac < 0)
            ac = 0;
        if (ac > C_PI)
            ac = C_PI;
        if (ng)
            ac = C_PI - ac;

        r = (q64_t'(ac) + (q64_t'(1) << (QF - FB - 1))) >> (QF - FB);
        return r[15:0];
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Mostly in-range cosines, plus raw 16-bit noise, values around
    // plus/minus one (both sides of the saturation point) and near zero.
    function automatic logic signed [15:0] pick_cos();
        int sel;
        int t;
        sel = $urandom_range(99);
        if (sel < 60)
            t = int'($urandom_range(2 * ONE_IN)) - ONE_IN;
        else if (sel < 74)
            t = int'($urandom_range(65535));
        else if (sel < 87)
        begin
            t = ONE_IN - 64 + int'($urandom_range(128));
            if ($urandom_range(1))
                t = -t;
        end
        else
            t = int'($urandom_range(128)) - 64;
        return 16'(t);
    endfunction

    // Offer one cosine, holding it until the transfer, then queue its angle.
    // Called at a rising edge; leaves off at the edge of the transfer.
    task automatic send_cos(input logic signed [15:0] c, input bit known,
                            input logic [15:0] typed_angle);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cos_value <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_angles.push_back(known ? typed_angle : predict_angle(c));
        items_sent++;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cos_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table first
        for (int i = 0; i < N_DIR; i++)
            send_cos(16'(dir_rows[i].cos), dir_rows[i].known, 16'(dir_rows[i].angle));

        // random part; a middle stretch runs with no idling on either side
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= CALM_FIRST && i <= CALM_LAST);
            send_cos(pick_cos(), 1'b0, '0);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain, then keep watching for stray transfers
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        if (mismatches == 0 && pending_angles.size() == 0)
            $display("** fast_arccos_approx_core: PASSED **");
        else
            $display("** fast_arccos_approx_core: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stall, calm stretch, and one long hold-off after
    // HOLD_AT transfers so the pipeline fills up and backs into in_stall
    // while the sender keeps offering.
    // ---------------------------------------------------------------
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------
    // Result checking: every output transfer against the oldest angle
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected angle transfer: got %0d", angle);
                mismatches++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (angle !== want)
                begin
                    if (mismatches < 10)
                        $display("angle mismatch: expected %0d, got %0d", want, angle);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("** fast_arccos_approx_core: FAILED **");
            $finish;
        end
    end

endmodule
